// File: hdl/snig_pkg.sv
package snig_pkg;

    localparam int MAX_GRID       = 256;
    localparam int MAX_RADIUS     = 2;
    localparam int MAX_COMPACT_R2 = 5;

    localparam int COORD_W = 8;
    localparam int GRID_W  = 9;
    localparam int PLANE_W = 17;
    localparam int LIN_W   = 24;
    localparam int D2_W    = 4;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] SHAPE_CUBE    = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE  = 2'd1;
    localparam logic [1:0] SHAPE_COMPACT = 2'd2;

    localparam logic [2:0] REG_SHAPE   = 3'd0;
    localparam logic [2:0] REG_RADIUS  = 3'd1;
    localparam logic [2:0] REG_COMPACT = 3'd2;
    localparam logic [2:0] REG_NX      = 3'd3;
    localparam logic [2:0] REG_NY      = 3'd4;
    localparam logic [2:0] REG_NZ      = 3'd5;

    typedef struct packed {
        logic [1:0]        stencil_shape;
        logic [1:0]        radius;
        logic [3:0]        compact_limit;
        logic [GRID_W-1:0] grid_nx;
        logic [GRID_W-1:0] grid_ny;
        logic [GRID_W-1:0] grid_nz;
    } cfg_t;

    // one host point, ready to walk
    typedef struct packed {
        logic               err;
        logic               keep_all;
        logic [D2_W-1:0]    d2_max;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] hy;
        logic [COORD_W-1:0] hz;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] z0;
        logic [COORD_W-1:0] z1;
        logic [GRID_W-1:0]  nz;
        logic [PLANE_W-1:0] nynz;
        logic [LIN_W-1:0]   base;
    } cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_z;
        logic [LIN_W-1:0]   linear_index;
        logic               last;
        logic               error;
    } res_t;

    // square of an axis offset in -2..2
    function automatic logic [2:0] sq_offset(input logic [2:0] d);
        logic [2:0] s;
        case (d)
            3'b000: s = 3'd0;
            3'b001: s = 3'd1;
            3'b111: s = 3'd1;
            3'b010: s = 3'd4;
            3'b110: s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [GRID_W-1:0] sat_grid(input logic [GRID_W-1:0] n);
        return (n > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : n;
    endfunction

endpackage

// File: hdl/snig_front.sv
module snig_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  snig_pkg::cfg_t           cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               host_x,
    input  logic [7:0]               host_y,
    input  logic [7:0]               host_z,
    output logic                     push,
    input  logic                     q_full,
    output snig_pkg::cmd_t           cmd
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CALC = 4'b0010,
        F_MUL  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [7:0]                    hx_reg, hy_reg, hz_reg;
    snig_pkg::cmd_t                cmd_reg, cmd_next;
    logic [snig_pkg::PLANE_W-1:0]  yz_reg, yz_next;

    logic [snig_pkg::GRID_W-1:0]   nx_s, ny_s, nz_s;
    logic [snig_pkg::GRID_W-1:0]   r_ext;
    logic [snig_pkg::GRID_W-1:0]   hx_hi, hy_hi, hz_hi;
    logic [7:0]                    x0_c, y0_c, z0_c;
    logic                          too_big;
    logic [16:0]                   nynz_full;
    logic [16:0]                   y0nz_full;
    logic [23:0]                   xoff_full;

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH);
    assign cmd      = cmd_reg;

    always_comb
    begin
        nx_s  = snig_pkg::sat_grid(cfg.grid_nx);
        ny_s  = snig_pkg::sat_grid(cfg.grid_ny);
        nz_s  = snig_pkg::sat_grid(cfg.grid_nz);
        r_ext = {7'd0, cfg.radius};
        hx_hi = {1'b0, hx_reg} + r_ext;
        hy_hi = {1'b0, hy_reg} + r_ext;
        hz_hi = {1'b0, hz_reg} + r_ext;
        x0_c  = (hx_reg >= {6'd0, cfg.radius}) ? hx_reg - {6'd0, cfg.radius} : 8'd0;
        y0_c  = (hy_reg >= {6'd0, cfg.radius}) ? hy_reg - {6'd0, cfg.radius} : 8'd0;
        z0_c  = (hz_reg >= {6'd0, cfg.radius}) ? hz_reg - {6'd0, cfg.radius} : 8'd0;
        too_big = (cfg.radius == 2'(snig_pkg::MAX_RADIUS)) &&
                  ((cfg.stencil_shape == snig_pkg::SHAPE_CUBE) ||
                   ((cfg.stencil_shape == snig_pkg::SHAPE_COMPACT) &&
                    (cfg.compact_limit > 4'(snig_pkg::MAX_COMPACT_R2))));
        nynz_full = {8'd0, ny_s} * {8'd0, nz_s};
        y0nz_full = {9'd0, y0_c} * {8'd0, nz_s};
        xoff_full = {16'd0, cmd_reg.x0} * {7'd0, cmd_reg.nynz};

        state_next = state_reg;
        cmd_next   = cmd_reg;
        yz_next    = yz_reg;

        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                    state_next = F_CALC;
            end
            F_CALC:
            begin
                cmd_next.err = (cfg.stencil_shape > snig_pkg::SHAPE_COMPACT) ||
                               (cfg.radius > 2'(snig_pkg::MAX_RADIUS)) ||
                               ({1'b0, hx_reg} >= nx_s) ||
                               ({1'b0, hy_reg} >= ny_s) ||
                               ({1'b0, hz_reg} >= nz_s) ||
                               too_big;
                cmd_next.keep_all = (cfg.stencil_shape == snig_pkg::SHAPE_CUBE);
                if (cfg.stencil_shape == snig_pkg::SHAPE_SPHERE)
                    cmd_next.d2_max = {1'b0, snig_pkg::sq_offset({1'b0, cfg.radius})};
                else
                    cmd_next.d2_max = cfg.compact_limit;
                cmd_next.hx   = hx_reg;
                cmd_next.hy   = hy_reg;
                cmd_next.hz   = hz_reg;
                cmd_next.x0   = x0_c;
                cmd_next.y0   = y0_c;
                cmd_next.z0   = z0_c;
                cmd_next.x1   = (hx_hi < nx_s) ? hx_hi[7:0] : 8'(nx_s - 9'd1);
                cmd_next.y1   = (hy_hi < ny_s) ? hy_hi[7:0] : 8'(ny_s - 9'd1);
                cmd_next.z1   = (hz_hi < nz_s) ? hz_hi[7:0] : 8'(nz_s - 9'd1);
                cmd_next.nz   = nz_s;
                cmd_next.nynz = nynz_full;
                yz_next       = y0nz_full + {9'd0, z0_c};
                state_next    = F_MUL;
            end
            F_MUL:
            begin
                cmd_next.base = xoff_full + {7'd0, yz_reg};
                state_next    = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hx_reg <= host_x;
            hy_reg <= host_y;
            hz_reg <= host_z;
        end
        cmd_reg <= cmd_next;
        yz_reg  <= yz_next;
    end

endmodule

// File: hdl/snig_queue.sv
module snig_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  snig_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output snig_pkg::cmd_t head
);

    localparam int PTR_W = $clog2(snig_pkg::QUEUE_DEPTH);

    snig_pkg::cmd_t     mem [snig_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(snig_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hdl/snig_back.sv
module snig_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  snig_pkg::cmd_t q_head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output snig_pkg::res_t out_res
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_WALK  = 3'b010,
        B_FLUSH = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    snig_pkg::cmd_t  cmd_reg, cmd_next;
    logic [7:0]      x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [snig_pkg::LIN_W-1:0] lin_reg, lin_next, row_reg, row_next, plane_reg, plane_next;
    snig_pkg::res_t  hold_reg, hold_next, out_reg, out_next;
    logic            hold_valid_reg, hold_valid_next, out_valid_reg, out_valid_next;

    logic [8:0]      dx_w, dy_w, dz_w;
    logic [3:0]      d2;
    logic            kept, out_free, step_ok;
    logic [snig_pkg::LIN_W-1:0] row_step, plane_step;
    snig_pkg::res_t  cand;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        dx_w = {1'b0, cmd_reg.hx} - {1'b0, x_reg};
        dy_w = {1'b0, cmd_reg.hy} - {1'b0, y_reg};
        dz_w = {1'b0, cmd_reg.hz} - {1'b0, z_reg};
        d2   = {1'b0, snig_pkg::sq_offset(dx_w[2:0])} +
               {1'b0, snig_pkg::sq_offset(dy_w[2:0])} +
               {1'b0, snig_pkg::sq_offset(dz_w[2:0])};
        kept    = cmd_reg.keep_all || (d2 <= cmd_reg.d2_max);
        step_ok = !(kept && hold_valid_reg && !out_free);
        row_step   = row_reg + {15'd0, cmd_reg.nz};
        plane_step = plane_reg + {7'd0, cmd_reg.nynz};

        cand.point_x      = x_reg;
        cand.point_y      = y_reg;
        cand.point_z      = z_reg;
        cand.linear_index = lin_reg;
        cand.last         = 1'b0;
        cand.error        = 1'b0;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        lin_next        = lin_reg;
        row_next        = row_reg;
        plane_next      = plane_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pop             = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.err)
                    begin
                        if (out_free)
                        begin
                            out_next       = '0;
                            out_next.last  = 1'b1;
                            out_next.error = 1'b1;
                            out_valid_next = 1'b1;
                            pop            = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_next   = q_head;
                        x_next     = q_head.x0;
                        y_next     = q_head.y0;
                        z_next     = q_head.z0;
                        lin_next   = q_head.base;
                        row_next   = q_head.base;
                        plane_next = q_head.base;
                        pop        = 1'b1;
                        state_next = B_WALK;
                    end
                end
            end
            B_WALK:
            begin
                if (step_ok)
                begin
                    if (kept)
                    begin
                        hold_next       = cand;
                        hold_valid_next = 1'b1;
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_valid_next = 1'b1;
                        end
                    end
                    if (z_reg != cmd_reg.z1)
                    begin
                        z_next   = z_reg + 8'd1;
                        lin_next = lin_reg + 24'd1;
                    end
                    else if (y_reg != cmd_reg.y1)
                    begin
                        y_next   = y_reg + 8'd1;
                        z_next   = cmd_reg.z0;
                        row_next = row_step;
                        lin_next = row_step;
                    end
                    else if (x_reg != cmd_reg.x1)
                    begin
                        x_next     = x_reg + 8'd1;
                        y_next     = cmd_reg.y0;
                        z_next     = cmd_reg.z0;
                        plane_next = plane_step;
                        row_next   = plane_step;
                        lin_next   = plane_step;
                    end
                    else
                    begin
                        state_next = B_FLUSH;
                    end
                end
            end
            B_FLUSH:
            begin
                if (out_free)
                begin
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        lin_reg   <= lin_next;
        row_reg   <= row_next;
        plane_reg <= plane_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

endmodule

// File: hdl/stencil_neighbor_index_generator_top.sv
// Stencil neighbor index generator. Each host point (x, y, z) accepted on the
// slave stream yields every grid point of the box of the configured radius around
// it, clipped to the grid and filtered by the stencil shape, walked with x
// outermost and z innermost; tlast marks the final point of a host, and a host
// that cannot be served (unknown shape, radius above 2, host outside the grid, or
// a stencil of more than 64 points such as a radius-2 cube) gives a single
// transaction with tuser set, tlast set and zero data. The front end takes each
// host point through accept, bounds and grid products, base index product and
// hand-off into a 2-entry queue before it accepts the next; the back end loads a
// host, visits one box candidate per cycle while no output stall holds the walk,
// and then closes the run. The slower of the two ends sets the sustained rate: the
// back end's candidate walk for most boxes, the front end's steps for errors and
// boxes of at most 2 clipped points. Output stalls hold the walk whenever a kept
// point cannot move on. Configuration writes take effect the next cycle and must
// only be issued while no host point is in flight.
module stencil_neighbor_index_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // host_x, host_y, host_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // point_x, point_y, point_z, linear_index
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // error
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    snig_pkg::cfg_t cfg_reg;
    snig_pkg::cmd_t front_cmd, q_head;
    snig_pkg::res_t res;
    logic           push, q_full, q_empty, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stencil_shape <= snig_pkg::SHAPE_CUBE;
            cfg_reg.radius        <= 2'd1;
            cfg_reg.compact_limit <= 4'(snig_pkg::MAX_COMPACT_R2);
            cfg_reg.grid_nx       <= 9'(snig_pkg::MAX_GRID);
            cfg_reg.grid_ny       <= 9'(snig_pkg::MAX_GRID);
            cfg_reg.grid_nz       <= 9'(snig_pkg::MAX_GRID);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                snig_pkg::REG_SHAPE:   cfg_reg.stencil_shape <= cfg_wdata[1:0];
                snig_pkg::REG_RADIUS:  cfg_reg.radius        <= cfg_wdata[1:0];
                snig_pkg::REG_COMPACT: cfg_reg.compact_limit <= cfg_wdata[3:0];
                snig_pkg::REG_NX:      cfg_reg.grid_nx       <= cfg_wdata;
                snig_pkg::REG_NY:      cfg_reg.grid_ny       <= cfg_wdata;
                snig_pkg::REG_NZ:      cfg_reg.grid_nz       <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    snig_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .host_x   (s_axis_tdata[7:0]),
        .host_y   (s_axis_tdata[15:8]),
        .host_z   (s_axis_tdata[23:16]),
        .push     (push),
        .q_full   (q_full),
        .cmd      (front_cmd)
    );

    snig_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    snig_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.linear_index, res.point_z, res.point_y, res.point_x};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.error;

endmodule
